>>> rtl/csil_pkg.sv
// shared types, sizes and codes for the classified sorted insertion lists
package csil_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int AGE_W      = 7;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef logic [AGE_W-1:0] age_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // gender codes
  localparam logic [1:0] GENDER_MALE   = 2'd1;
  localparam logic [1:0] GENDER_FEMALE = 2'd2;

  // list selectors
  localparam logic [1:0] SEL_TEEN   = 2'd0;
  localparam logic [1:0] SEL_FEMALE = 2'd1;
  localparam logic [1:0] SEL_MALE   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // full flag bit positions
  localparam int FULL_TEEN   = 0;
  localparam int FULL_FEMALE = 1;
  localparam int FULL_MALE   = 2;

  // per-cell control from the list to one cell
  typedef struct packed {
    logic ins;     // insert this cycle into a list that has room
    logic occ;     // cell holds a stored entry
    logic at_end;  // cell is the first free slot
  } csil_cell_ctrl_t;

endpackage

>>> rtl/csil_cell.sv
// one compare-and-shift cell of a sorted list chain
module csil_cell
  import csil_pkg::*;
(
  input  logic            clk,
  input  csil_cell_ctrl_t ctrl,
  input  age_t            new_age,
  input  logic            prev_gt,
  input  age_t            prev_age,
  output logic            gt,
  output age_t            age
);

  age_t age_r;
  age_t age_nxt;

  // stored entry lies after the new one (equal keys stay in front)
  assign gt  = ctrl.occ && (age_r > new_age);
  assign age = age_r;

  always_comb begin
    age_nxt = age_r;
    if (ctrl.ins) begin
      if (prev_gt) begin
        age_nxt = prev_age;
      end else if (gt || ctrl.at_end) begin
        age_nxt = new_age;
      end
    end
  end

  always_ff @(posedge clk) begin
    age_r <= age_nxt;
  end

endmodule

>>> rtl/csil_list.sv
// one sorted list: chain of cells, fill count and read port
module csil_list
  import csil_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic ins,
  input  logic clr,
  input  age_t new_age,
  input  idx_t rd_idx,
  output age_t rd_age,
  output cnt_t count,
  output logic full
);

  cnt_t count_r;
  cnt_t count_nxt;
  logic ins_ok;

  logic [LIST_DEPTH-1:0] gt;
  age_t                  ages [LIST_DEPTH];

  assign full   = (count_r == cnt_t'(LIST_DEPTH));
  assign ins_ok = ins && !full;
  assign count  = count_r;
  assign rd_age = ages[rd_idx];

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    csil_cell_ctrl_t ctrl;
    logic            prev_gt;
    age_t            prev_age;

    assign ctrl.ins    = ins_ok;
    assign ctrl.occ    = cnt_t'(k) < count_r;
    assign ctrl.at_end = cnt_t'(k) == count_r;

    if (k == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_age = '0;
    end else begin : g_link
      assign prev_gt  = gt[k-1];
      assign prev_age = ages[k-1];
    end

    csil_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_age  (new_age),
      .prev_gt  (prev_gt),
      .prev_age (prev_age),
      .gt       (gt[k]),
      .age      (ages[k])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (ins_ok) begin
      count_nxt = count_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/classified_sorted_insertion_lists.sv
// top level: three sorted age lists with insert, readout and clear
// input channel (in_valid / in_stall): one transaction per command; in_op
//   selects insert, readout or clear, in_age, in_gender and in_list_sel are
//   the operands. in_stall is high while a readout streams and while the
//   output register holds a result that the receiver stalls.
// result channel (out_valid / out_stall): insert, clear and unknown ops give
//   one acknowledge transaction; a readout gives one transaction per stored
//   entry in ascending order, or one empty marker, with last on the final one.
// config channel (cfg_valid / cfg_ready): writes the adult age threshold;
//   always ready, to be written only while the block is idle.
// timing: an acknowledge or empty marker is registered, in the cycle after
//   its command, so inserts and clears run at one per cycle unless stalled,
//   each list being a chain of LIST_DEPTH compare-and-shift cells that places
//   the new age as the command is taken. a readout enters the read state,
//   then puts out one entry per cycle unless stalled; the next command goes
//   in once the read state is left. a stalled result holds output and input.
// reset: rst_n (sync, active low) empties all lists, sets the threshold to
//   20 and drops any pending result; stored ages themselves are not cleared.
module classified_sorted_insertion_lists
  import csil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // command input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [AGE_W-1:0] in_age,
  input  logic [1:0]       in_gender,
  input  logic [1:0]       in_list_sel,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [AGE_W-1:0] out_age_out,
  output logic [2:0]       out_full_mask,
  output logic             out_last,
  // threshold register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [AGE_W-1:0] cfg_adult_age
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;

  age_t       adult_age_r;
  logic [1:0] sel_r, sel_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       last_idx_r, last_idx_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  age_t       out_age_r, out_age_nxt;
  logic [2:0] out_full_r, out_full_nxt;
  logic       out_last_r, out_last_nxt;

  logic slot_free;
  logic in_acc;
  logic is_insert;
  logic is_clear;

  // list ports
  logic teen_ins, female_ins, male_ins;
  age_t teen_rd, female_rd, male_rd;
  cnt_t teen_cnt, female_cnt, male_cnt;
  logic teen_full, female_full, male_full;

  cnt_t sel_cnt;
  cnt_t sel_cnt_m1;
  age_t rd_age;

  // output slot can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign is_insert = in_acc && (in_op == OP_INSERT);
  assign is_clear  = in_acc && (in_op == OP_CLEAR);

  // classification of an insert
  assign teen_ins   = is_insert && (in_age < adult_age_r);
  assign female_ins = is_insert && (in_gender == GENDER_FEMALE);
  assign male_ins   = is_insert && (in_gender == GENDER_MALE);

  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_age_out   = out_age_r;
  assign out_full_mask = out_full_r;
  assign out_last      = out_last_r;

  csil_list u_teen (
    .clk     (clk),
    .rst_n   (rst_n),
    .ins     (teen_ins),
    .clr     (is_clear),
    .new_age (in_age),
    .rd_idx  (idx_r),
    .rd_age  (teen_rd),
    .count   (teen_cnt),
    .full    (teen_full)
  );

  csil_list u_female (
    .clk     (clk),
    .rst_n   (rst_n),
    .ins     (female_ins),
    .clr     (is_clear),
    .new_age (in_age),
    .rd_idx  (idx_r),
    .rd_age  (female_rd),
    .count   (female_cnt),
    .full    (female_full)
  );

  csil_list u_male (
    .clk     (clk),
    .rst_n   (rst_n),
    .ins     (male_ins),
    .clr     (is_clear),
    .new_age (in_age),
    .rd_idx  (idx_r),
    .rd_age  (male_rd),
    .count   (male_cnt),
    .full    (male_full)
  );

  // fill count of the list asked for by a readout command
  always_comb begin
    unique case (in_list_sel)
      SEL_TEEN:   sel_cnt = teen_cnt;
      SEL_FEMALE: sel_cnt = female_cnt;
      SEL_MALE:   sel_cnt = male_cnt;
      default:    sel_cnt = '0;  // unused selector reads as empty
    endcase
  end

  assign sel_cnt_m1 = sel_cnt - cnt_t'(1);

  // entry of the list being streamed
  always_comb begin
    unique case (sel_r)
      SEL_TEEN:   rd_age = teen_rd;
      SEL_FEMALE: rd_age = female_rd;
      SEL_MALE:   rd_age = male_rd;
      default:    rd_age = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    out_kind_nxt  = out_kind_r;
    out_age_nxt   = out_age_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_age_nxt   = '0;
          out_full_nxt  = '0;
          out_last_nxt  = 1'b1;
          unique case (in_op)
            OP_INSERT: begin
              out_full_nxt[FULL_TEEN]   = teen_ins && teen_full;
              out_full_nxt[FULL_FEMALE] = female_ins && female_full;
              out_full_nxt[FULL_MALE]   = male_ins && male_full;
            end
            OP_READ: begin
              if (sel_cnt == '0) begin
                out_kind_nxt = KIND_EMPTY;
              end else begin
                // first entry goes out from the read state
                out_valid_nxt = 1'b0;
                state_nxt     = ST_READ;
                sel_nxt       = in_list_sel;
                idx_nxt       = '0;
                last_idx_nxt  = sel_cnt_m1[IDX_W-1:0];
              end
            end
            default: begin
              // clear and unused op: plain acknowledge
            end
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ENTRY;
          out_age_nxt   = rd_age;
          out_full_nxt  = '0;
          out_last_nxt  = (idx_r == last_idx_r);
          if (idx_r == last_idx_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + idx_t'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      adult_age_r <= age_t'(20);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        adult_age_r <= cfg_adult_age;
      end
    end
    sel_r      <= sel_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_age_r  <= out_age_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
